[hdl/grid_region_merge_labeler_defines.svh]
// ----------------------------------------------------------------------------
// Grid region merge labeler assertion macros
// Shared assertion forms, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef GRID_REGION_MERGE_LABELER_DEFINES_SVH
`define GRID_REGION_MERGE_LABELER_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define GRML_ASSERT_IMP(lbl, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");

// antecedent implies consequent in the following cycle
`define GRML_ASSERT_NXT(lbl, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");

`endif

[hdl/grml_pkg.sv]
// ----------------------------------------------------------------------------
// Grid region merge labeler package
// Fixed widths and constants shared by the cell chain and the controller.
// ----------------------------------------------------------------------------
package grml_pkg;

    localparam int SIZE_W  = 8;
    localparam int LBL_O_W = 7;

    localparam logic [SIZE_W-1:0] SIZE_MAX = 8'd255;

    typedef logic [SIZE_W-1:0] size_t;

endpackage

[hdl/grid_region_merge_labeler.sv]
// ----------------------------------------------------------------------------
// Grid region merge labeler
// Online 4-connected region labeling over a ring of grid cells.
// ----------------------------------------------------------------------------
// A transaction is accepted when start is high and busy is low. The grid
// state lives in a ring of N = GRID_WIDTH*GRID_HEIGHT cells that rotates one
// place per cycle while a pass runs; each pass brings every cell past one
// head slot. A transaction takes three passes (neighbor gather, relabel/merge,
// size scan) plus a decision step. The result is shown for one cycle with done
// high and cannot be stalled; a new transaction may be accepted in that cycle.
`include "grid_region_merge_labeler_defines.svh"

module grid_region_merge_labeler
    import grml_pkg::*;
#(
    parameter int GRID_WIDTH  = 16,
    parameter int GRID_HEIGHT = 8
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [3:0]   col,
    input  logic [2:0]   row,
    output logic         busy,
    output logic         done,
    output logic [6:0]   cell_label,
    output logic [7:0]   label_size,
    output logic [6:0]   largest_label,
    output logic [7:0]   largest_size,
    output logic         out_of_labels
);

    localparam int N   = GRID_WIDTH * GRID_HEIGHT;
    localparam int LW  = (N > 1) ? $clog2(N) : 1;
    localparam int NLW = $clog2(N + 1);

    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_GATHER = 3'd1;
    localparam logic [2:0] PH_DECIDE = 3'd2;
    localparam logic [2:0] PH_MERGE  = 3'd3;
    localparam logic [2:0] PH_SCAN   = 3'd4;

    logic          cv [N];
    logic [LW-1:0] cl [N];
    size_t         cs [N];

    logic          hv, nv, shift;
    logic [LW-1:0] hl, nl;
    size_t         hs, ns;

    logic [2:0]     ph_reg, ph_next;
    logic [LW-1:0]  k_reg, k_next;
    logic [LW-1:0]  idx_reg, idx_next;
    logic           ingrid_reg, ingrid_next;
    logic [3:0]     nbin_reg, nbin_next;
    logic [LW-1:0]  nbidx_reg [4];
    logic [LW-1:0]  nbidx_next [4];
    logic [3:0]     has_reg, has_next;
    logic [LW-1:0]  nb_reg [4];
    logic [LW-1:0]  nb_next [4];
    logic [LW-1:0]  minl_reg, minl_next;
    logic           wr_reg, wr_next;
    logic           flag_reg, flag_next;
    logic [NLW-1:0] nxt_reg, nxt_next;
    size_t          base_reg, base_next;
    size_t          sum_reg, sum_next;
    size_t          best_reg, best_next;
    logic [LW-1:0]  bestl_reg, bestl_next;
    logic           done_reg;
    logic [6:0]     cell_label_reg, largest_label_reg;
    size_t          label_size_reg, largest_size_reg;
    logic           ool_reg;

    logic [12:0]    idx_full;
    logic [LW-1:0]  idx_c;
    logic           any_c;
    logic [LW-1:0]  min_c;
    logic           l_merge, k_merge, last;
    logic [8:0]     sum_t;
    logic [9:0]     tot_t;
    size_t          final_c;

    assign shift = (ph_reg == PH_GATHER) || (ph_reg == PH_MERGE) || (ph_reg == PH_SCAN);
    assign last  = (k_reg == LW'(N - 1));

    genvar g;
    generate
        for (g = 0; g < N; g++)
        begin : g_ring
            if (g == N - 1)
            begin : g_tail
                grml_cell #(.LW(LW)) u_cell (
                    .clk(clk), .rst_n(rst_n), .shift(shift),
                    .d_valid(nv), .d_label(nl), .d_size(ns),
                    .q_valid(cv[g]), .q_label(cl[g]), .q_size(cs[g])
                );
            end
            else
            begin : g_body
                grml_cell #(.LW(LW)) u_cell (
                    .clk(clk), .rst_n(rst_n), .shift(shift),
                    .d_valid(cv[g+1]), .d_label(cl[g+1]), .d_size(cs[g+1]),
                    .q_valid(cv[g]), .q_label(cl[g]), .q_size(cs[g])
                );
            end
        end
    endgenerate

    assign hv = cv[0];
    assign hl = cl[0];
    assign hs = cs[0];

    assign idx_full = 13'(col) * 13'(GRID_HEIGHT) + 13'(row);
    assign idx_c    = idx_full[LW-1:0];

    always_comb
    begin
        any_c = 1'b0;
        min_c = '0;
        for (int j = 0; j < 4; j++)
        begin
            if (has_reg[j] && (!any_c || nb_reg[j] < min_c))
            begin
                min_c = nb_reg[j];
                any_c = 1'b1;
            end
        end
    end

    always_comb
    begin
        l_merge = 1'b0;
        k_merge = 1'b0;
        for (int j = 0; j < 4; j++)
        begin
            if (has_reg[j] && nb_reg[j] != minl_reg)
            begin
                if (nb_reg[j] == hl)
                    l_merge = 1'b1;
                if (nb_reg[j] == k_reg)
                    k_merge = 1'b1;
            end
        end
    end

    assign sum_t   = 9'(sum_reg) + 9'(hs);
    assign tot_t   = 10'(base_reg) + 10'd1 + 10'(sum_reg);
    assign final_c = (tot_t > 10'(SIZE_MAX)) ? SIZE_MAX : tot_t[7:0];

    always_comb
    begin
        ph_next     = ph_reg;
        k_next      = k_reg;
        idx_next    = idx_reg;
        ingrid_next = ingrid_reg;
        nbin_next   = nbin_reg;
        nbidx_next  = nbidx_reg;
        has_next    = has_reg;
        nb_next     = nb_reg;
        minl_next   = minl_reg;
        wr_next     = wr_reg;
        flag_next   = flag_reg;
        nxt_next    = nxt_reg;
        base_next   = base_reg;
        sum_next    = sum_reg;
        best_next   = best_reg;
        bestl_next  = bestl_reg;
        nv          = hv;
        nl          = hl;
        ns          = hs;

        case (ph_reg)
            PH_IDLE:
            begin
                if (start)
                begin
                    ph_next       = PH_GATHER;
                    k_next        = '0;
                    idx_next      = idx_c;
                    ingrid_next   = (32'(col) < 32'(GRID_WIDTH)) &&
                                    (32'(row) < 32'(GRID_HEIGHT));
                    nbin_next[0]  = (32'(row) + 32'd1 < 32'(GRID_HEIGHT));
                    nbin_next[1]  = (row != 3'd0);
                    nbin_next[2]  = (col != 4'd0);
                    nbin_next[3]  = (32'(col) + 32'd1 < 32'(GRID_WIDTH));
                    nbidx_next[0] = idx_c + LW'(1);
                    nbidx_next[1] = idx_c - LW'(1);
                    nbidx_next[2] = idx_c - LW'(GRID_HEIGHT);
                    nbidx_next[3] = idx_c + LW'(GRID_HEIGHT);
                    has_next      = '0;
                end
            end
            PH_GATHER:
            begin
                for (int j = 0; j < 4; j++)
                begin
                    if (ingrid_reg && nbin_reg[j] && k_reg == nbidx_reg[j])
                    begin
                        has_next[j] = hv;
                        nb_next[j]  = hl;
                    end
                end
                k_next = last ? '0 : k_reg + LW'(1);
                if (last)
                    ph_next = PH_DECIDE;
            end
            PH_DECIDE:
            begin
                wr_next   = 1'b0;
                flag_next = 1'b0;
                minl_next = min_c;
                base_next = '0;
                sum_next  = '0;
                best_next = '0;
                bestl_next = '0;
                if (ingrid_reg)
                begin
                    if (!any_c)
                    begin
                        if (nxt_reg >= NLW'(N))
                            flag_next = 1'b1;
                        else
                        begin
                            wr_next   = 1'b1;
                            minl_next = nxt_reg[LW-1:0];
                            nxt_next  = nxt_reg + NLW'(1);
                        end
                    end
                    else
                        wr_next = 1'b1;
                end
                ph_next = PH_MERGE;
            end
            PH_MERGE:
            begin
                if (wr_reg)
                begin
                    if (k_reg == idx_reg)
                    begin
                        nv = 1'b1;
                        nl = minl_reg;
                    end
                    else if (hv && l_merge)
                        nl = minl_reg;
                    if (k_reg == minl_reg)
                        base_next = hs;
                    if (k_merge)
                    begin
                        sum_next = (sum_t > 9'(SIZE_MAX)) ? SIZE_MAX : sum_t[7:0];
                        ns       = '0;
                    end
                end
                k_next = last ? '0 : k_reg + LW'(1);
                if (last)
                    ph_next = PH_SCAN;
            end
            PH_SCAN:
            begin
                if (wr_reg && k_reg == minl_reg)
                    ns = final_c;
                if (ns > best_reg)
                begin
                    best_next  = ns;
                    bestl_next = k_reg;
                end
                k_next = last ? '0 : k_reg + LW'(1);
                if (last)
                    ph_next = PH_IDLE;
            end
            default:
            begin
                ph_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg   <= PH_IDLE;
            k_reg    <= '0;
            nxt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            ph_reg   <= ph_next;
            k_reg    <= k_next;
            nxt_reg  <= nxt_next;
            done_reg <= (ph_reg == PH_SCAN) && last;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        ingrid_reg <= ingrid_next;
        nbin_reg   <= nbin_next;
        nbidx_reg  <= nbidx_next;
        has_reg    <= has_next;
        nb_reg     <= nb_next;
        minl_reg   <= minl_next;
        wr_reg     <= wr_next;
        flag_reg   <= flag_next;
        base_reg   <= base_next;
        sum_reg    <= sum_next;
        best_reg   <= best_next;
        bestl_reg  <= bestl_next;
        if ((ph_reg == PH_SCAN) && last)
        begin
            cell_label_reg    <= wr_reg ? 7'(minl_reg) : 7'd0;
            label_size_reg    <= wr_reg ? final_c : '0;
            largest_label_reg <= 7'(bestl_next);
            largest_size_reg  <= best_next;
            ool_reg           <= flag_reg;
        end
    end

    assign busy          = (ph_reg != PH_IDLE);
    assign done          = done_reg;
    assign cell_label    = cell_label_reg;
    assign label_size    = label_size_reg;
    assign largest_label = largest_label_reg;
    assign largest_size  = largest_size_reg;
    assign out_of_labels = ool_reg;

    `GRML_ASSERT_IMP(a_done_idle, done_reg, ph_reg == PH_IDLE)
    `GRML_ASSERT_NXT(a_accept_busy, start && !busy, busy && ph_reg == PH_GATHER)
    `GRML_ASSERT_IMP(a_flag_empty, done_reg && ool_reg, cell_label_reg == 7'd0 && label_size_reg == 8'd0)
    `GRML_ASSERT_IMP(a_next_bound, 1'b1, nxt_reg <= NLW'(N))

endmodule

[hdl/grml_cell.sv]
// ----------------------------------------------------------------------------
// Grid region merge labeler cell
// One ring stage: a grid entry (valid, label) and the size of one label.
// ----------------------------------------------------------------------------
module grml_cell
    import grml_pkg::*;
#(
    parameter int LW = 7
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          shift,
    input  logic          d_valid,
    input  logic [LW-1:0] d_label,
    input  size_t         d_size,
    output logic          q_valid,
    output logic [LW-1:0] q_label,
    output size_t         q_size
);

    logic          valid_reg;
    logic [LW-1:0] label_reg;
    size_t         size_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            size_reg  <= '0;
        end
        else if (shift)
        begin
            valid_reg <= d_valid;
            size_reg  <= d_size;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            label_reg <= d_label;
        end
    end

    assign q_valid = valid_reg;
    assign q_label = label_reg;
    assign q_size  = size_reg;

endmodule
